// ----- design/palette_tile_blitter_core_defines.svh -----
// ----------------------------------------------------------------------------
// Palette tile blitter assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef PALETTE_TILE_BLITTER_CORE_DEFINES_SVH
`define PALETTE_TILE_BLITTER_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define PTB_ASSERT_SAME(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ptb: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent
`define PTB_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ptb: next-cycle check failed");

`endif

// ----- design/ptb_pkg.sv -----
// ----------------------------------------------------------------------------
// Palette tile blitter package
// Shared widths, register and function codes, and the placement struct.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptb_pkg;

  // Default configuration of the design
  localparam int TileSizeDef     = 16;
  localparam int PaletteDepthDef = 256;

  // Field widths
  localparam int CoordW = 12;  // frame width / height / stride / clipped coords
  localparam int PosW   = 16;  // signed tile origin
  localparam int IndexW = 8;   // palette index and slot
  localparam int SizeW  = 9;   // palette size register
  localparam int ColorW = 16;  // RGB565
  localparam int AddrW  = 24;  // frame buffer word address

  // Stream and config port widths
  localparam int STdataW = 72;
  localparam int STuserW = 2;
  localparam int MTdataW = 40;
  localparam int CfgIdxW = 2;

  // Register reset values
  localparam logic [CoordW-1:0] FrameWidthRst  = CoordW'(320);
  localparam logic [CoordW-1:0] FrameHeightRst = CoordW'(240);
  localparam logic [CoordW-1:0] RowStrideRst   = CoordW'(320);
  localparam logic [SizeW-1:0]  PaletteSizeRst = '0;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_ROW_STRIDE   = 2'd2,
    REG_PALETTE_SIZE = 2'd3
  } cfg_reg_e;

  // Item kinds
  typedef enum logic {
    FUNC_PIXEL = 1'b0,
    FUNC_LOAD  = 1'b1
  } func_e;

  // Placement of one pixel, from the position unit to the pipeline
  typedef struct packed {
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    logic              on_frame;
  } place_t;

endpackage

// ----- design/ptb_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/ptb_place.sv -----
// ----------------------------------------------------------------------------
// Palette tile blitter position unit
// Keeps the tile origin, mirror flag and source pixel counter, places each
// pixel in the frame and checks it against the frame bounds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptb_place #(
  parameter int TILE_SIZE = ptb_pkg::TileSizeDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,     // pixel transaction taken
  input  logic                        start_i,
  input  logic [ptb_pkg::PosW-1:0]    tile_x_i,
  input  logic [ptb_pkg::PosW-1:0]    tile_y_i,
  input  logic                        mirror_i,
  input  logic [ptb_pkg::CoordW-1:0]  frame_width_i,
  input  logic [ptb_pkg::CoordW-1:0]  frame_height_i,
  output ptb_pkg::place_t             place_o
);

  import ptb_pkg::*;

  localparam int            CW      = $clog2(TILE_SIZE);
  localparam logic [CW-1:0] LastIdx = CW'(TILE_SIZE - 1);

  logic [PosW-1:0] org_x_q, org_y_q;
  logic            mirror_q;
  logic [CW-1:0]   col_q, row_q;

  logic [PosW-1:0] org_x, org_y;
  logic            mirror;
  logic [CW-1:0]   col_cur, row_cur, offset;
  logic [CW-1:0]   col_d, row_d;
  logic [PosW-1:0] dcol, drow;

  // A start pixel uses its own origin and a cleared counter
  always_comb begin
    org_x   = start_i ? tile_x_i : org_x_q;
    org_y   = start_i ? tile_y_i : org_y_q;
    mirror  = start_i ? mirror_i : mirror_q;
    col_cur = start_i ? '0 : col_q;
    row_cur = start_i ? '0 : row_q;
  end

  // Destination position, wraps at 16 bits
  always_comb begin
    offset = mirror ? (LastIdx - col_cur) : col_cur;
    dcol   = org_x + PosW'(offset);
    drow   = org_y + PosW'(row_cur);
  end

  // Clip: negative or at/after the frame edge
  always_comb begin
    place_o.col      = dcol[CoordW-1:0];
    place_o.row      = drow[CoordW-1:0];
    place_o.on_frame = !dcol[PosW-1] && (dcol[PosW-2:0] < (PosW-1)'(frame_width_i)) &&
                       !drow[PosW-1] && (drow[PosW-2:0] < (PosW-1)'(frame_height_i));
  end

  // Counter advance, row steps when the column wraps
  always_comb begin
    col_d = (col_cur == LastIdx) ? '0 : col_cur + CW'(1);
    row_d = row_cur;
    if (col_cur == LastIdx) begin
      row_d = (row_cur == LastIdx) ? '0 : row_cur + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q  <= '0;
      org_y_q  <= '0;
      mirror_q <= 1'b0;
      col_q    <= '0;
      row_q    <= '0;
    end else if (step_i) begin
      org_x_q  <= org_x;
      org_y_q  <= org_y;
      mirror_q <= mirror;
      col_q    <= col_d;
      row_q    <= row_d;
    end
  end

endmodule

// ----- design/palette_tile_blitter_core.sv -----
// Path: a drawn pixel is registered in stage 1 together with its palette RAM read, then
// in the output register, from which it is offered on the master side.
// Throughput: one item per clock unless the master side stalls; each item makes at most one
// palette RAM access in its accept cycle: a read for a pixel or a write for a palette load to a slot below the depth.
// Reset: config registers, origin, mirror and pixel counter reset; the palette RAM
// is not cleared and the block takes items from the first cycle after reset.
// ----------------------------------------------------------------------------
// Palette tile blitter top level
// Palette-indexed tile blitter with color key and frame clipping: placement,
// palette RAM lookup and frame buffer address generation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "palette_tile_blitter_core_defines.svh"

module palette_tile_blitter_core #(
  parameter int TILE_SIZE     = ptb_pkg::TileSizeDef,
  parameter int PALETTE_DEPTH = ptb_pkg::PaletteDepthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration writes
  input  logic                         cfg_we_i,
  input  logic [ptb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ptb_pkg::CoordW-1:0]   cfg_wdata_i,
  // Input stream
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // tile_x[15:0], tile_y[31:16], mirror[32], pixel_index[40:33],
  // palette_slot[48:41], palette_color[64:49], zero pad[71:65]
  input  logic [ptb_pkg::STdataW-1:0]  s_axis_tdata_i,
  // func[0], start_tile[1]
  input  logic [ptb_pkg::STuserW-1:0]  s_axis_tuser_i,
  // Output stream
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // write_address[23:0], write_color[39:24]
  output logic [ptb_pkg::MTdataW-1:0]  m_axis_tdata_o
);

  import ptb_pkg::*;

  localparam int             RamAw    = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam logic [SizeW-1:0] PalDepth = SizeW'(PALETTE_DEPTH);

  // Configuration registers
  logic [CoordW-1:0] frame_width_q, frame_height_q, row_stride_q;
  logic [SizeW-1:0]  palette_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FrameWidthRst;
      frame_height_q <= FrameHeightRst;
      row_stride_q   <= RowStrideRst;
      palette_size_q <= PaletteSizeRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata_i;
        REG_FRAME_HEIGHT: frame_height_q <= cfg_wdata_i;
        REG_ROW_STRIDE:   row_stride_q   <= cfg_wdata_i;
        REG_PALETTE_SIZE: palette_size_q <= cfg_wdata_i[SizeW-1:0];
      endcase
    end
  end

  // Input unpacking
  logic              func;
  logic              start_tile;
  logic [PosW-1:0]   tile_x, tile_y;
  logic              mirror;
  logic [IndexW-1:0] pixel_index, palette_slot;
  logic [ColorW-1:0] palette_color;

  assign func          = s_axis_tuser_i[0];
  assign start_tile    = s_axis_tuser_i[1];
  assign tile_x        = s_axis_tdata_i[15:0];
  assign tile_y        = s_axis_tdata_i[31:16];
  assign mirror        = s_axis_tdata_i[32];
  assign pixel_index   = s_axis_tdata_i[40:33];
  assign palette_slot  = s_axis_tdata_i[48:41];
  assign palette_color = s_axis_tdata_i[64:49];

  // Pipeline flow control
  logic s1_valid_q, out_valid_q;
  logic out_adv, s1_adv, accept, is_load, pix_step;

  assign out_adv         = !out_valid_q || m_axis_tready_i;
  assign s1_adv          = !s1_valid_q || out_adv;
  assign s_axis_tready_o = s1_adv;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign is_load         = (func == FUNC_LOAD);
  assign pix_step        = accept && !is_load;

  // Pixel placement and clipping
  place_t place;

  ptb_place #(
    .TILE_SIZE (TILE_SIZE)
  ) u_place (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (pix_step),
    .start_i        (start_tile),
    .tile_x_i       (tile_x),
    .tile_y_i       (tile_y),
    .mirror_i       (mirror),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .place_o        (place)
  );

  // Palette RAM: loads write, pixels read; the read sees any earlier write
  logic              ram_we, idx_ok;
  logic [ColorW-1:0] ram_rdata;

  assign ram_we = accept && is_load && ({1'b0, palette_slot} < PalDepth);
  assign idx_ok = (pixel_index != '0) && ({1'b0, pixel_index} < palette_size_q) &&
                  ({1'b0, pixel_index} < PalDepth);

  ptb_ram #(
    .WIDTH (ColorW),
    .DEPTH (PALETTE_DEPTH),
    .AW    (RamAw)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (palette_slot[RamAw-1:0]),
    .wdata_i (palette_color),
    .re_i    (pix_step),
    .raddr_i (pixel_index[RamAw-1:0]),
    .rdata_o (ram_rdata)
  );

  // Stage 1: drawn pixel coordinates, waiting on the RAM read
  logic [CoordW-1:0] s1_col_q, s1_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_q <= pix_step && idx_ok && place.on_frame;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_step) begin
      s1_col_q <= place.col;
      s1_row_q <= place.row;
    end
  end

  // Address generation: row * stride + column, 24-bit wrap
  logic [AddrW-1:0] row_base, addr_d;

  assign row_base = AddrW'(s1_row_q) * AddrW'(row_stride_q);
  assign addr_d   = row_base + AddrW'(s1_col_q);

  // Output register
  logic [AddrW-1:0]  out_addr_q;
  logic [ColorW-1:0] out_color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && s1_valid_q) begin
      out_addr_q  <= addr_d;
      out_color_q <= ram_rdata;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_color_q, out_addr_q};

  // Checks
  `PTB_ASSERT_SAME(a_full_stall, clk_i, rst_ni,
                   s1_valid_q && out_valid_q && !m_axis_tready_i, !s_axis_tready_o)
  `PTB_ASSERT_NEXT(a_drawn_enters_s1, clk_i, rst_ni,
                   pix_step && idx_ok && place.on_frame, s1_valid_q)
  `PTB_ASSERT_SAME(a_ram_write_only_on_load, clk_i, rst_ni,
                   ram_we, accept && is_load && !pix_step)

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// Palette tile blitter testbench
// Drives tile pixel and palette load transactions into the blitter and
// checks each frame buffer write against a cycle-free placement model.
// A short directed table covers reset state, frame edges, wrap, mirror
// and palette bounds. Random tiles then run under several register
// settings with source gaps, sink stalls and one long sink hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import ptb_pkg::*;

  localparam int TileSz      = TileSizeDef;
  localparam int ColW        = $clog2(TileSz);  // tile counters, tile size is a power of 2
  localparam int DrainCycles = 4;
  localparam int StallLimit  = 2000;            // cycles without any transaction

  // Where a transaction's expected write comes from
  typedef enum {EXP_MODEL, EXP_NONE, EXP_WRITE} exp_src_e;
  typedef enum {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    logic [AddrW-1:0]  addr;
    logic [ColorW-1:0] color;
  } fb_write_t;

  typedef struct {
    row_kind_e         kind;
    cfg_reg_e          reg_sel;
    logic [CoordW-1:0] reg_val;
    func_e             func;
    logic              start;
    logic [PosW-1:0]   tx;
    logic [PosW-1:0]   ty;
    logic              mir;
    logic [IndexW-1:0] idx;
    logic [IndexW-1:0] slot;
    logic [ColorW-1:0] color;
    exp_src_e          chk;
    fb_write_t         want;
  } blit_row_t;

  // DUT ports
  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                cfg_we_i        = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i       = '0;
  logic [CoordW-1:0]   cfg_wdata_i     = '0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [STdataW-1:0]  s_axis_tdata_i  = '0;
  logic [STuserW-1:0]  s_axis_tuser_i  = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [MTdataW-1:0]  m_axis_tdata_o;

  // Placement model state
  logic [ColorW-1:0]   pal_mem [PaletteDepthDef];
  logic [PosW-1:0]     org_col    = '0;
  logic [PosW-1:0]     org_row    = '0;
  logic                org_mirror = 1'b0;
  logic [ColW-1:0]     pix_col    = '0;
  logic [ColW-1:0]     pix_row    = '0;
  logic [CoordW-1:0]   fw_q       = FrameWidthRst;
  logic [CoordW-1:0]   fh_q       = FrameHeightRst;
  logic [CoordW-1:0]   stride_q   = RowStrideRst;
  logic [SizeW-1:0]    psize_q    = PaletteSizeRst;

  fb_write_t           fb_writes_q[$];
  exp_src_e            cur_chk  = EXP_MODEL;
  fb_write_t           cur_want = '0;
  int                  mismatch_cnt  = 0;
  int                  quiet_cycles  = 0;
  int                  src_idle_pct  = 0;
  int                  rcv_stall_pct = 0;
  int                  rcv_hold      = 0;

  palette_tile_blitter_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #2 clk_i = ~clk_i;

  // Place one accepted transaction; returns 1 when it yields a frame buffer write
  function automatic bit place_pixel(input logic [STdataW-1:0] data,
                                     input logic [STuserW-1:0] user,
                                     output fb_write_t wr);
    logic [ColW-1:0]   offs;
    logic [PosW-1:0]   dcol;
    logic [PosW-1:0]   drow;
    logic [IndexW-1:0] idx;
    logic [SizeW-1:0]  lim;
    wr = '0;
    if (func_e'(user[0]) == FUNC_LOAD) begin
      pal_mem[data[48:41]] = data[64:49];
      return 1'b0;
    end
    if (user[1]) begin
      org_col    = data[15:0];
      org_row    = data[31:16];
      org_mirror = data[32];
      pix_col    = '0;
      pix_row    = '0;
    end
    idx  = data[40:33];
    offs = org_mirror ? ColW'(TileSz - 1) - pix_col : pix_col;
    dcol = org_col + PosW'(offs);
    drow = org_row + PosW'(pix_row);
    // counter steps on every pixel, drawn or not
    pix_col = pix_col + 1'b1;
    if (pix_col == '0) pix_row = pix_row + 1'b1;
    lim = (psize_q > SizeW'(PaletteDepthDef)) ? SizeW'(PaletteDepthDef) : psize_q;
    if (dcol[PosW-1] || dcol >= PosW'(fw_q) || drow[PosW-1] || drow >= PosW'(fh_q) ||
        idx == '0 || SizeW'(idx) >= lim)
      return 1'b0;
    wr.addr  = AddrW'(32'(drow) * 32'(stride_q) + 32'(dcol));
    wr.color = pal_mem[idx];
    return 1'b1;
  endfunction

  function automatic blit_row_t cfg_row(input cfg_reg_e sel, input logic [CoordW-1:0] val);
    blit_row_t r;
    r = '{kind: ROW_CFG, reg_sel: sel, reg_val: val, func: FUNC_PIXEL, chk: EXP_NONE,
          want: '0, default: '0};
    return r;
  endfunction

  // Stray start/origin/mirror on a load must be ignored by the block
  function automatic blit_row_t load_row(input logic [IndexW-1:0] slot,
                                         input logic [ColorW-1:0] color, input logic stray);
    blit_row_t r;
    r = '{kind: ROW_ITEM, reg_sel: REG_FRAME_WIDTH, func: FUNC_LOAD, chk: EXP_MODEL,
          want: '0, default: '0};
    r.slot  = slot;
    r.color = color;
    r.start = stray;
    r.tx    = stray ? PosW'($urandom) : '0;
    r.ty    = stray ? PosW'($urandom) : '0;
    r.mir   = stray;
    r.idx   = IndexW'($urandom);
    return r;
  endfunction

  function automatic blit_row_t pixel_row(input logic start, input logic [PosW-1:0] x,
                                          input logic [PosW-1:0] y, input logic mir,
                                          input logic [IndexW-1:0] idx, input exp_src_e chk,
                                          input logic [AddrW-1:0] addr,
                                          input logic [ColorW-1:0] color);
    blit_row_t r;
    r = '{kind: ROW_ITEM, reg_sel: REG_FRAME_WIDTH, func: FUNC_PIXEL, chk: chk,
          default: '0};
    r.start      = start;
    r.tx         = x;
    r.ty         = y;
    r.mir        = mir;
    r.idx        = idx;
    r.slot       = IndexW'($urandom);
    r.color      = ColorW'($urandom);
    r.want.addr  = addr;
    r.want.color = color;
    return r;
  endfunction

  // Offer one transaction, with random source gaps, and hold it until accepted
  task automatic drive_item(input blit_row_t r);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = {7'd0, r.color, r.slot, r.idx, r.mir, r.ty, r.tx};
    s_axis_tuser_i  = {r.start, r.func};
    cur_chk         = r.chk;
    cur_want        = r.want;
    do @(posedge clk_i); while (s_axis_tready_o !== 1'b1);
    @(negedge clk_i);
  endtask

  // Block idle: no write outstanding, dropped pixels drained from the pipe
  task automatic settle();
    s_axis_tvalid_i = 1'b0;
    while (fb_writes_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e sel, input logic [CoordW-1:0] val);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = sel;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    case (sel)
      REG_FRAME_WIDTH:  fw_q     = val;
      REG_FRAME_HEIGHT: fh_q     = val;
      REG_ROW_STRIDE:   stride_q = val;
      REG_PALETTE_SIZE: psize_q  = val[SizeW-1:0];
      default: ;
    endcase
  endtask

  // Random tiles: mostly whole tiles with a start, some short or overlong runs,
  // a few that carry on from the latched origin, loads sprinkled in between
  task automatic random_tiles(input int n_items);
    int              left;
    int              len;
    logic [PosW-1:0] x;
    logic [PosW-1:0] y;
    logic            mir;
    bit              fresh;
    logic [IndexW-1:0] idx;
    left = n_items;
    while (left > 0) begin
      case ($urandom_range(9))
        6, 7:    len = $urandom_range(40, 1);
        8, 9:    len = $urandom_range(320, 257);
        default: len = TileSz * TileSz;
      endcase
      if ($urandom_range(9) == 0) begin
        x = PosW'($urandom);
        y = PosW'($urandom);
      end else begin
        x = PosW'(int'($urandom_range(int'(fw_q) + 32)) - 16);
        y = PosW'(int'($urandom_range(int'(fh_q) + 32)) - 16);
      end
      mir   = 1'($urandom);
      fresh = ($urandom_range(9) != 0);
      for (int k = 0; k < len && left > 0; k++) begin
        idx = ($urandom_range(99) < 15) ? '0 : IndexW'($urandom_range(255, 1));
        if (k != 0 && $urandom_range(99) < 5)
          drive_item(load_row(IndexW'($urandom), ColorW'($urandom), 1'($urandom)));
        else if (k == 0)
          drive_item(pixel_row(fresh, x, y, mir, idx, EXP_MODEL, '0, '0));
        else
          drive_item(pixel_row(1'b0, PosW'($urandom), PosW'($urandom), 1'($urandom), idx,
                               EXP_MODEL, '0, '0));
        left--;
      end
    end
  endtask

  task automatic run_phase(input logic [CoordW-1:0] fw, input logic [CoordW-1:0] fh,
                           input logic [CoordW-1:0] stride, input logic [CoordW-1:0] psize,
                           input int src_pct, input int rcv_pct, input int hold,
                           input bit fill, input int n_items);
    settle();
    write_reg(REG_FRAME_WIDTH, fw);
    write_reg(REG_FRAME_HEIGHT, fh);
    write_reg(REG_ROW_STRIDE, stride);
    write_reg(REG_PALETTE_SIZE, psize);
    src_idle_pct  = src_pct;
    rcv_stall_pct = rcv_pct;
    rcv_hold      = hold;
    if (fill)
      for (int s = 0; s < PaletteDepthDef; s++)
        drive_item(load_row(IndexW'(s), ColorW'($urandom), 1'($urandom)));
    random_tiles(n_items);
  endtask

  // Sink ready: long hold-off when requested, else random stalls
  always @(negedge clk_i) begin
    if (rcv_hold > 0) begin
      m_axis_tready_i = 1'b0;
      rcv_hold--;
    end else begin
      m_axis_tready_i = ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // Predict on input transactions, then check output transactions
  always @(posedge clk_i) begin
    fb_write_t calc;
    fb_write_t want;
    fb_write_t got;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o === 1'b1) begin
        if (place_pixel(s_axis_tdata_i, s_axis_tuser_i, calc) && cur_chk == EXP_MODEL)
          fb_writes_q.push_back(calc);
        if (cur_chk == EXP_WRITE) fb_writes_q.push_back(cur_want);
      end
      if (m_axis_tvalid_o === 1'b1 && m_axis_tready_i) begin
        got.addr  = m_axis_tdata_o[23:0];
        got.color = m_axis_tdata_o[39:24];
        if (fb_writes_q.size() == 0) begin
          $display("%0t: write expected none actual addr %h color %h", $time, got.addr,
                   got.color);
          mismatch_cnt++;
        end else begin
          want = fb_writes_q.pop_front();
          if (got.addr !== want.addr) begin
            $display("%0t: write_address expected %h actual %h", $time, want.addr, got.addr);
            mismatch_cnt++;
          end
          if (got.color !== want.color) begin
            $display("%0t: write_color expected %h actual %h", $time, want.color, got.color);
            mismatch_cnt++;
          end
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o === 1'b1) ||
        (m_axis_tvalid_o === 1'b1 && m_axis_tready_i))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("%0t: no transaction for %0d cycles", $time, StallLimit);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    blit_row_t dir_tbl[$];

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table; only the listed palette slots are used before the full fill
    dir_tbl.push_back(load_row(8'h00, 16'h1234, 1'b0));
    dir_tbl.push_back(load_row(8'h01, 16'hFFFF, 1'b0));
    dir_tbl.push_back(load_row(8'hFF, 16'h8001, 1'b0));
    dir_tbl.push_back(load_row(8'h55, 16'hAAAA, 1'b0));
    dir_tbl.push_back(load_row(8'hAA, 16'h5555, 1'b0));
    // palette size is 0 after reset: nothing drawn
    dir_tbl.push_back(pixel_row(1'b1, 16'd0, 16'd0, 1'b0, 8'd1, EXP_NONE, '0, '0));
    dir_tbl.push_back(cfg_row(REG_PALETTE_SIZE, 12'd256));
    dir_tbl.push_back(pixel_row(1'b1, 16'd0, 16'd0, 1'b0, 8'd1, EXP_WRITE, 24'd0, 16'hFFFF));
    // transparent index, then origin fields ignored without a start
    dir_tbl.push_back(pixel_row(1'b0, 16'h7FFF, 16'h7FFF, 1'b1, 8'd0, EXP_NONE, '0, '0));
    dir_tbl.push_back(pixel_row(1'b0, 16'hFFFF, 16'h0000, 1'b1, 8'hFF, EXP_WRITE,
                                24'd2, 16'h8001));
    // left edge clip, then the next column lands on column 0
    dir_tbl.push_back(pixel_row(1'b1, 16'hFFFF, 16'd0, 1'b0, 8'd1, EXP_NONE, '0, '0));
    dir_tbl.push_back(pixel_row(1'b0, 16'd0, 16'd0, 1'b0, 8'd1, EXP_MODEL, '0, '0));
    // mirrored tile hitting the bottom right pixel of the frame
    dir_tbl.push_back(pixel_row(1'b1, 16'd304, 16'd239, 1'b1, 8'hAA, EXP_WRITE,
                                24'd76799, 16'h5555));
    dir_tbl.push_back(pixel_row(1'b0, 16'd0, 16'd0, 1'b0, 8'h55, EXP_MODEL, '0, '0));
    // column wraps from the top of the signed range to the bottom
    dir_tbl.push_back(pixel_row(1'b1, 16'h7FFF, 16'd0, 1'b0, 8'd1, EXP_NONE, '0, '0));
    dir_tbl.push_back(pixel_row(1'b0, 16'd0, 16'd0, 1'b0, 8'd1, EXP_MODEL, '0, '0));
    dir_tbl.push_back(pixel_row(1'b1, 16'h8000, 16'h8000, 1'b1, 8'hFF, EXP_NONE, '0, '0));
    dir_tbl.push_back(pixel_row(1'b1, 16'd0, 16'd240, 1'b0, 8'd1, EXP_NONE, '0, '0));
    dir_tbl.push_back(pixel_row(1'b1, 16'd320, 16'd0, 1'b1, 8'd1, EXP_MODEL, '0, '0));
    dir_tbl.push_back(pixel_row(1'b1, 16'd10, 16'd5, 1'b0, 8'd1, EXP_WRITE, 24'd1610, 16'hFFFF));
    // load with a stray start leaves the tile counter alone
    dir_tbl.push_back(load_row(8'h02, 16'h0F0F, 1'b1));
    dir_tbl.push_back(pixel_row(1'b0, 16'd0, 16'd0, 1'b0, 8'd2, EXP_MODEL, '0, '0));
    // index at the palette size is not drawn
    dir_tbl.push_back(cfg_row(REG_PALETTE_SIZE, 12'd2));
    dir_tbl.push_back(pixel_row(1'b1, 16'd0, 16'd0, 1'b0, 8'd1, EXP_WRITE, 24'd0, 16'hFFFF));
    dir_tbl.push_back(pixel_row(1'b0, 16'd0, 16'd0, 1'b0, 8'd2, EXP_NONE, '0, '0));
    // largest frame; palette size beyond the depth acts as the depth
    dir_tbl.push_back(cfg_row(REG_FRAME_WIDTH, 12'd4095));
    dir_tbl.push_back(cfg_row(REG_FRAME_HEIGHT, 12'd4095));
    dir_tbl.push_back(cfg_row(REG_ROW_STRIDE, 12'd4095));
    dir_tbl.push_back(cfg_row(REG_PALETTE_SIZE, 12'h1FF));
    dir_tbl.push_back(pixel_row(1'b1, 16'd4080, 16'd4094, 1'b1, 8'hFF, EXP_NONE, '0, '0));
    dir_tbl.push_back(pixel_row(1'b0, 16'd0, 16'd0, 1'b0, 8'hFF, EXP_WRITE,
                                24'd16769024, 16'h8001));

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].kind == ROW_CFG) begin
        settle();
        write_reg(dir_tbl[i].reg_sel, dir_tbl[i].reg_val);
      end else begin
        drive_item(dir_tbl[i]);
      end
    end

    // Random phases: register setting, source idle %, sink stall %, hold-off, palette fill, item count
    run_phase(12'd320,  12'd240,  12'd320,  12'd256, 0,  0,  0,   1'b1, 300);
    run_phase(12'd4095, 12'd4095, 12'd4095, 12'd200, 55, 0,  0,   1'b0, 300);
    run_phase(12'd0,    12'd100,  12'd0,    12'h1FF, 0,  55, 0,   1'b0, 60);
    run_phase(12'd100,  12'd4095, 12'd0,    12'd16,  0,  55, 0,   1'b0, 250);
    run_phase(12'd1,    12'd1,    12'd1,    12'd2,   34, 34, 0,   1'b0, 120);
    run_phase(12'd320,  12'd240,  12'd320,  12'd256, 0,  0,  300, 1'b0, 300);
    run_phase(12'd4095, 12'd50,   12'd4095, 12'd256, 34, 34, 0,   1'b0, 300);

    // Drain
    s_axis_tvalid_i = 1'b0;
    rcv_stall_pct   = 0;
    while (fb_writes_q.size() != 0) @(negedge clk_i);
    repeat (2 * DrainCycles) @(negedge clk_i);
    if (mismatch_cnt == 0 && fb_writes_q.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/ptb_pkg.sv
design/ptb_ram.sv
design/ptb_place.sv
design/palette_tile_blitter_core.sv
dv/tb.sv
